FILE: sv/sphtex_pkg.sv
// Shared types and constants for the spherical texture coordinate block.
`timescale 1ns / 1ps

package sphtex_pkg;

  // Vertex beat: Q12.4 coordinates and the strip end mark.
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               is_last;
  } vtx_t;

  // Result beat: Q6.14 texture coordinates and the strip end mark.
  typedef struct packed {
    logic signed [19:0] tex_u;
    logic signed [19:0] tex_v;
    logic               last_out;
  } tex_t;

  localparam int CFG_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int ATAN_N     = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int DP_W       = 36;   // CORDIC datapath width
  localparam int PROD_W     = 40;   // tiling product width
  localparam int COORD_W    = 20;

  localparam logic [CFG_IDX_W-1:0] REG_H_TILE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_V_TILE = 1'b1;

  localparam logic signed [DP_W-1:0]   ANG_PI   = 36'sd2147483648;
  localparam logic signed [31:0]       GAIN_Q30 = 32'sd1768195363;
  localparam logic signed [PROD_W-1:0] U_BIAS   = 40'sd2147614720; // pi plus rounding half
  localparam logic signed [PROD_W-1:0] V_HALF   = 40'sd32768;
  localparam logic signed [COORD_W:0]  SEAM_U   = 21'sd14745;
  localparam logic signed [COORD_W:0]  SEAM_V   = 21'sd13107;
  localparam logic signed [COORD_W:0]  ONE_Q14  = 21'sd16384;
  localparam logic signed [COORD_W:0]  OUT_MAX  = 21'sd524287;

  // Arctangent of 2^-i in binary angle units (pi = 2^31).
  function automatic logic [29:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/spherical_texcoord_with_seam_fix.sv
// Spherical texture coordinate generator with strip seam repair.
`timescale 1ns / 1ps

// Usage
//   vtx channel: one vertex per beat (vtx_valid / vtx_stall). The block raises
//   vtx_stall while it works on a vertex and drops it when idle.
//   tex channel: zero to three result beats per vertex (tex_valid / tex_stall),
//   held in an output register, so a finished result may wait while the next
//   vertex is taken.
//   cfg port: cfg_we writes cfg_data into h_tile (index 0) or v_tile (index 1);
//   write only while idle.
// Operation
//   One shared CORDIC add/shift unit runs two vectoring passes back to back
//   for each vertex, then 6 seam compare steps once three vertices are held,
//   then the result beats go out; a stalled receiver holds up the emit phase.
// Reset
//   rst (synchronous) empties the vertex window, drops tex_valid and sets
//   both tiling factors to 1.
module spherical_texcoord_with_seam_fix #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vtx_valid,
  output logic                                 vtx_stall,
  input  sphtex_pkg::vtx_t                     vtx_data,
  output logic                                 tex_valid,
  input  logic                                 tex_stall,
  output sphtex_pkg::tex_t                     tex_data,
  input  logic                                 cfg_we,
  input  logic [sphtex_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sphtex_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NITER  = (CORDIC_ITERATIONS < sphtex_pkg::ATAN_N) ?
                          CORDIC_ITERATIONS : sphtex_pkg::ATAN_N;
  localparam int ITER_W = $clog2(NITER);
  localparam int W      = sphtex_pkg::DP_W;
  localparam int CW     = sphtex_pkg::COORD_W;
  localparam int PW     = sphtex_pkg::PROD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ZMUL = 4'd1;
  localparam logic [3:0] S_PRE  = 4'd2;
  localparam logic [3:0] S_ITER = 4'd3;
  localparam logic [3:0] S_END  = 4'd4;
  localparam logic [3:0] S_UV   = 4'd5;
  localparam logic [3:0] S_SEAM = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;

  logic [3:0]              state;
  logic [ITER_W-1:0]       iter;
  logic                    pass;          // 0: atan2 pass, 1: asin pass
  logic                    last_r;
  logic signed [15:0]      pos_z_r;
  logic signed [30:0]      zk;
  logic signed [W-1:0]     hx, vy, ang, ang1;
  logic [sphtex_pkg::CFG_W-1:0] h_tile, v_tile;

  // Vertex window, oldest first; cnt counts held entries.
  logic signed [CW-1:0]    wu [0:2];
  logic signed [CW-1:0]    wv [0:2];
  logic [1:0]              cnt;
  logic [2:0]              step;

  logic                    vtx_take, tex_load, emit_done;

  // Shared CORDIC unit
  logic [sphtex_pkg::ATAN_IDX_W-1:0] iter_idx;
  logic signed [W-1:0]     xs_sh, ys_sh, atan_v;
  logic signed [46:0]      zprod;

  // Scaling
  logic signed [PW-1:0]    pu, pv;
  logic signed [PW-1:0]    su, sv;
  logic signed [CW-1:0]    cu, cv;

  // Seam step
  logic [1:0]              pidx, qidx;
  logic signed [CW:0]      du, dv, qu_inc, qv_inc;
  logic signed [CW-1:0]    qu_new, qv_new;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] x);
    logic signed [CW-1:0] r;
    if (x > PW'(sphtex_pkg::OUT_MAX)) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (x < -PW'(sphtex_pkg::OUT_MAX) - PW'(1)) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  assign vtx_stall = (state != S_IDLE);
  assign vtx_take  = vtx_valid && !vtx_stall;

  // Shared add/shift unit operands
  always_comb begin
    iter_idx = sphtex_pkg::ATAN_IDX_W'(iter);
    xs_sh    = hx >>> iter_idx;
    ys_sh    = vy >>> iter_idx;
    atan_v   = W'(sphtex_pkg::atan_entry(iter_idx));
    zprod    = 47'(pos_z_r) * 47'(sphtex_pkg::GAIN_Q30);
  end

  // Tiling, rounding and saturation of both coordinates
  always_comb begin
    pu = $signed({{(PW-sphtex_pkg::CFG_W){1'b0}}, h_tile}) * PW'(ang1);
    pv = $signed({{(PW-sphtex_pkg::CFG_W){1'b0}}, v_tile}) * PW'(ang);
    su = (pu + sphtex_pkg::U_BIAS) >>> 18;
    sv = (pv + sphtex_pkg::V_HALF) >>> 16;
    cu = sat_coord(su);
    cv = sat_coord(sv);
  end

  // Seam pair order: a-b, b-a, a-c, c-a, b-c, c-b
  always_comb begin
    case (step)
      3'd0:    begin pidx = 2'd0; qidx = 2'd1; end
      3'd1:    begin pidx = 2'd1; qidx = 2'd0; end
      3'd2:    begin pidx = 2'd0; qidx = 2'd2; end
      3'd3:    begin pidx = 2'd2; qidx = 2'd0; end
      3'd4:    begin pidx = 2'd1; qidx = 2'd2; end
      3'd5:    begin pidx = 2'd2; qidx = 2'd1; end
      default: begin pidx = 2'd0; qidx = 2'd1; end
    endcase
    du     = (CW+1)'(wu[pidx]) - (CW+1)'(wu[qidx]);
    dv     = (CW+1)'(wv[pidx]) - (CW+1)'(wv[qidx]);
    qu_inc = (CW+1)'(wu[qidx]) + sphtex_pkg::ONE_Q14;
    qv_inc = (CW+1)'(wv[qidx]) + sphtex_pkg::ONE_Q14;
    if (du > sphtex_pkg::SEAM_U) begin
      qu_new = (qu_inc > sphtex_pkg::OUT_MAX) ? CW'(sphtex_pkg::OUT_MAX) : qu_inc[CW-1:0];
    end else begin
      qu_new = wu[qidx];
    end
    if (dv > sphtex_pkg::SEAM_V) begin
      qv_new = (qv_inc > sphtex_pkg::OUT_MAX) ? CW'(sphtex_pkg::OUT_MAX) : qv_inc[CW-1:0];
    end else begin
      qv_new = wv[qidx];
    end
  end

  // Emit the oldest entry while the flush or the full window calls for it.
  assign emit_done = last_r ? (cnt == 2'd0) : (cnt != 2'd3);
  assign tex_load  = (state == S_EMIT) && !emit_done && (!tex_valid || !tex_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h_tile <= sphtex_pkg::CFG_W'(1);
      v_tile <= sphtex_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sphtex_pkg::REG_H_TILE: h_tile <= cfg_data;
        sphtex_pkg::REG_V_TILE: v_tile <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_valid <= 1'b0;
    end else if (tex_load) begin
      tex_valid <= 1'b1;
    end else if (!tex_stall) begin
      tex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tex_load) begin
      tex_data.tex_u    <= wu[0];
      tex_data.tex_v    <= wv[0];
      tex_data.last_out <= last_r && (cnt == 2'd1);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 2'd0;
      iter  <= '0;
      step  <= 3'd0;
      pass  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (vtx_take) begin
            hx      <= {{(W-30){vtx_data.pos_y[15]}}, vtx_data.pos_y, 14'b0};
            vy      <= {{(W-30){vtx_data.pos_x[15]}}, vtx_data.pos_x, 14'b0};
            pos_z_r <= vtx_data.pos_z;
            last_r  <= vtx_data.is_last;
            pass    <= 1'b0;
            state   <= S_ZMUL;
          end
        end
        S_ZMUL: begin
          zk    <= zprod[46:16];
          state <= S_PRE;
        end
        S_PRE: begin
          iter <= '0;
          if (hx == '0 && vy == '0) begin
            ang   <= '0;
            state <= S_END;
          end else begin
            if (hx[W-1]) begin
              ang <= vy[W-1] ? -sphtex_pkg::ANG_PI : sphtex_pkg::ANG_PI;
              hx  <= -hx;
              vy  <= -vy;
            end else begin
              ang <= '0;
            end
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (!vy[W-1]) begin
            hx  <= hx + ys_sh;
            vy  <= vy - xs_sh;
            ang <= ang + atan_v;
          end else begin
            hx  <= hx - ys_sh;
            vy  <= vy + xs_sh;
            ang <= ang - atan_v;
          end
          if (iter == ITER_W'(NITER - 1)) begin
            state <= S_END;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_END: begin
          if (!pass) begin
            // Hand the gain-scaled planar length and K*z to the second pass.
            ang1  <= ang;
            vy    <= W'(zk);
            pass  <= 1'b1;
            state <= S_PRE;
          end else begin
            state <= S_UV;
          end
        end
        S_UV: begin
          wu[cnt] <= cu;
          wv[cnt] <= cv;
          cnt     <= cnt + 2'd1;
          step    <= 3'd0;
          state   <= (cnt == 2'd2) ? S_SEAM : S_EMIT;
        end
        S_SEAM: begin
          wu[qidx] <= qu_new;
          wv[qidx] <= qv_new;
          step     <= step + 3'd1;
          if (step == 3'd5) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_done) begin
            state <= S_IDLE;
          end else if (tex_load) begin
            wu[0] <= wu[1];
            wu[1] <= wu[2];
            wv[0] <= wv[1];
            wv[1] <= wv[2];
            cnt   <= cnt - 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/texcoord_checker.sv
// Checker for the spherical texture coordinate block: predicts and compares result beats.
`timescale 1ns / 1ps

module texcoord_checker #(
  parameter int ITERATIONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vtx_valid,
  input  logic                                 vtx_stall,
  input  sphtex_pkg::vtx_t                     vtx_data,
  input  logic                                 tex_valid,
  input  logic                                 tex_stall,
  input  sphtex_pkg::tex_t                     tex_data,
  input  logic                                 cfg_we,
  input  logic [sphtex_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sphtex_pkg::CFG_W-1:0]         cfg_data,
  output int                                   fail_count,
  output int                                   outstanding,
  output int                                   beats_checked
);

  localparam longint PI_BAM     = 64'sd2147483648;
  localparam longint GAIN_K     = 64'sd1768195363;
  localparam longint COORD_ONE  = 64'sd16384;
  localparam int     U_SEAM_GAP = 14745;
  localparam int     V_SEAM_GAP = 13107;
  localparam int     LIFT_Q14   = 16384;
  localparam int     COORD_HI   = 524287;
  localparam int     COORD_LO   = -524288;

  // Arctangent of 2^-i, pi = 2^31.
  longint atan_bam [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  int   h_cfg      = 1;
  int   v_cfg      = 1;
  int   pend_u [0:1];
  int   pend_v [0:1];
  int   held       = 0;
  int   mismatches = 0;
  int   checked    = 0;
  int   queued     = 0;
  sphtex_pkg::tex_t want_tex [$];

  assign fail_count    = mismatches;
  assign beats_checked = checked;
  assign outstanding   = queued;

  function automatic int clip20(input longint val);
    if (val > COORD_HI) return COORD_HI;
    if (val < COORD_LO) return COORD_LO;
    return int'(val);
  endfunction

  // Vectoring pass; a zero vector gives angle 0.
  function automatic longint cordic_angle(input longint hx_in, input longint vy_in,
                                          output longint mag);
    longint hx, vy, ang, xs, ys;
    hx  = hx_in;
    vy  = vy_in;
    ang = 0;
    mag = 0;
    if (hx == 0 && vy == 0) return 0;
    if (hx < 0) begin
      ang = (vy >= 0) ? PI_BAM : -PI_BAM;
      hx  = -hx;
      vy  = -vy;
    end
    for (int i = 0; i < ITERATIONS && i < 24; i++) begin
      xs = hx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        hx  = hx + ys;
        vy  = vy - xs;
        ang = ang + atan_bam[i];
      end else begin
        hx  = hx - ys;
        vy  = vy + xs;
        ang = ang - atan_bam[i];
      end
    end
    mag = hx;
    return ang;
  endfunction

  function automatic int lifted(input int hi, input int lo, input int gap);
    if (longint'(hi) - longint'(lo) > gap) return clip20(longint'(lo) + LIFT_Q14);
    return lo;
  endfunction

  // Window (a, b, c), oldest first.
  task automatic seam_repair(inout int a, inout int b, inout int c, input int gap);
    b = lifted(a, b, gap);
    a = lifted(b, a, gap);
    c = lifted(a, c, gap);
    a = lifted(c, a, gap);
    c = lifted(b, c, gap);
    b = lifted(c, b, gap);
  endtask

  function automatic sphtex_pkg::tex_t make_beat(input int u, input int v, input bit last);
    sphtex_pkg::tex_t t;
    t.tex_u    = u[19:0];
    t.tex_v    = v[19:0];
    t.last_out = last;
    return t;
  endfunction

  task automatic predict_tex_beats(input sphtex_pkg::vtx_t vx);
    longint rho, spare, a1, a2, zk;
    int     cu, cv;
    a1 = cordic_angle(longint'($signed(vx.pos_y)) * COORD_ONE,
                      longint'($signed(vx.pos_x)) * COORD_ONE, rho);
    zk = (longint'($signed(vx.pos_z)) * COORD_ONE * GAIN_K) >>> 30;
    a2 = cordic_angle(rho, zk, spare);
    cu = clip20((longint'(h_cfg) * a1 + PI_BAM + 64'sd131072) >>> 18);
    cv = clip20((longint'(v_cfg) * a2 + 64'sd32768) >>> 16);

    if (held == 2) begin
      seam_repair(pend_u[0], pend_u[1], cu, U_SEAM_GAP);
      seam_repair(pend_v[0], pend_v[1], cv, V_SEAM_GAP);
      want_tex.push_back(make_beat(pend_u[0], pend_v[0], 1'b0));
      pend_u[0] = pend_u[1];
      pend_v[0] = pend_v[1];
      pend_u[1] = cu;
      pend_v[1] = cv;
    end else begin
      pend_u[held] = cu;
      pend_v[held] = cv;
      held++;
    end

    if (vx.is_last) begin
      for (int i = 0; i < held; i++)
        want_tex.push_back(make_beat(pend_u[i], pend_v[i], i + 1 == held));
      held      = 0;
      pend_u[0] = 0;
      pend_u[1] = 0;
      pend_v[0] = 0;
      pend_v[1] = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    sphtex_pkg::tex_t want;
    if (rst) begin
      h_cfg     = 1;
      v_cfg     = 1;
      held      = 0;
      pend_u[0] = 0;
      pend_u[1] = 0;
      pend_v[0] = 0;
      pend_v[1] = 0;
      want_tex.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sphtex_pkg::REG_H_TILE: h_cfg = int'(cfg_data);
          sphtex_pkg::REG_V_TILE: v_cfg = int'(cfg_data);
          default: ;
        endcase
      end
      if (vtx_valid && !vtx_stall) predict_tex_beats(vtx_data);
      if (tex_valid && !tex_stall) begin
        if (want_tex.size() == 0) begin
          $display("%0t unexpected beat: u %0d v %0d last %0b", $time,
                   tex_data.tex_u, tex_data.tex_v, tex_data.last_out);
          mismatches++;
        end else begin
          want = want_tex.pop_front();
          checked++;
          if (tex_data.tex_u !== want.tex_u) begin
            $display("%0t tex_u mismatch: expected %0d, actual %0d", $time,
                     want.tex_u, tex_data.tex_u);
            mismatches++;
          end
          if (tex_data.tex_v !== want.tex_v) begin
            $display("%0t tex_v mismatch: expected %0d, actual %0d", $time,
                     want.tex_v, tex_data.tex_v);
            mismatches++;
          end
          if (tex_data.last_out !== want.last_out) begin
            $display("%0t last_out mismatch: expected %0b, actual %0b", $time,
                     want.last_out, tex_data.last_out);
            mismatches++;
          end
        end
      end
    end
    queued <= want_tex.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the spherical texture coordinate block: stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int N_ITER      = 16;
  localparam int IDLE_PAUSE  = 100;  // cycles to let a vertex with no result drain
  localparam int LONG_HOLD   = 600;  // receiver hold that backs the block up
  localparam int MAX_GAP     = 18;
  localparam int PHASES      = 10;
  localparam int PHASE_VERTS = 20;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             vtx_valid = 1'b0;
  logic                             vtx_stall;
  sphtex_pkg::vtx_t                 vtx_data  = '0;
  logic                             tex_valid;
  logic                             tex_stall = 1'b0;
  sphtex_pkg::tex_t                 tex_data;
  logic                             cfg_we    = 1'b0;
  logic [sphtex_pkg::CFG_IDX_W-1:0] cfg_index = sphtex_pkg::REG_H_TILE;
  logic [sphtex_pkg::CFG_W-1:0]     cfg_data  = '0;

  int fail_count;
  int outstanding;
  int beats_checked;

  // Flags shared between the sender and the receiver, and run counters.
  bit steady    = 1'b0;  // no idle cycles on either side while set
  int hold_len  = 0;     // one-shot long hold for the receiver
  int verts_sent = 0;
  int strips_sent = 0;
  int settings_run = 0;

  spherical_texcoord_with_seam_fix #(
    .CORDIC_ITERATIONS(N_ITER)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx_data  (vtx_data),
    .tex_valid (tex_valid),
    .tex_stall (tex_stall),
    .tex_data  (tex_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  texcoord_checker #(
    .ITERATIONS(N_ITER)
  ) chk (
    .clk           (clk),
    .rst           (rst),
    .vtx_valid     (vtx_valid),
    .vtx_stall     (vtx_stall),
    .vtx_data      (vtx_data),
    .tex_valid     (tex_valid),
    .tex_stall     (tex_stall),
    .tex_data      (tex_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .beats_checked (beats_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offer one vertex beat after a random gap and hold it until the block
  // takes it. Valid stays high across back-to-back beats, so it never gets
  // lowered and raised in the same step.
  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      vtx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_valid        <= 1'b1;
    vtx_data.pos_x   <= x;
    vtx_data.pos_y   <= y;
    vtx_data.pos_z   <= z;
    vtx_data.is_last <= last;
    do @(posedge clk); while (vtx_stall);
    verts_sent++;
    if (last) strips_sent++;
  endtask

  // Drop valid, wait for every expected beat, then give the block time to
  // finish any vertex that produced nothing yet.
  task automatic wait_idle();
    vtx_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Write both tiling factors on consecutive edges; only called while idle.
  task automatic set_tiling(input int h, input int v);
    cfg_we    <= 1'b1;
    cfg_index <= sphtex_pkg::REG_H_TILE;
    cfg_data  <= h[sphtex_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= sphtex_pkg::REG_V_TILE;
    cfg_data  <= v[sphtex_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_run++;
  endtask

  // One strip of random vertices. Mix full-range values with points close to
  // the u seam (negative y, x near zero), close to the poles (large |z|),
  // partly zero vertices and tiny ones.
  task automatic send_strip(input int len);
    int pick;
    int x, y, z;
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else if (pick < 60) begin
        x = int'($urandom_range(0, 128)) - 64;
        y = -int'($urandom_range(256, 32768));
        z = int'($urandom_range(0, 8192)) - 4096;
      end else if (pick < 80) begin
        x = int'($urandom_range(0, 64)) - 32;
        y = int'($urandom_range(0, 64)) - 32;
        z = $urandom_range(0, 1) ? int'($urandom_range(16384, 32767))
                                 : -int'($urandom_range(16384, 32768));
      end else if (pick < 90) begin
        x = $urandom_range(0, 1) ? 0 : $urandom;
        y = $urandom_range(0, 1) ? 0 : $urandom;
        z = $urandom_range(0, 1) ? 0 : $urandom;
      end else begin
        x = int'($urandom_range(0, 32)) - 16;
        y = int'($urandom_range(0, 32)) - 16;
        z = int'($urandom_range(0, 32)) - 16;
      end
      send_vertex(x[15:0], y[15:0], z[15:0], k == len - 1);
    end
  endtask

  // Receiver: stall a random number of cycles before each beat, except in
  // steady phases, and take the one long hold when the stimulus asks for it.
  initial begin : drain
    int n;
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
      end else begin
        n = steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        tex_stall <= 1'b1;
        repeat (n) @(posedge clk);
        tex_stall <= 1'b0;
      end
      do @(posedge clk); while (!tex_valid);
    end
  end

  initial begin : stimulus
    int h, v, len, phase_verts;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset tiling of 1.
    // All-zero vertex alone: both passes see a zero vector, one-vertex strip.
    send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b1);
    // Two-vertex strip at the coordinate extremes: no window, no repair.
    send_vertex(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    // Longer strip: zero planar length with nonzero z, negative y on both
    // sides of the u seam, both poles; ends with a three-beat flush.
    send_vertex(16'sd0, 16'sd0, 16'sh8000, 1'b0);
    send_vertex(16'sd0, 16'sh8000, 16'sd0, 1'b0);
    send_vertex(-16'sd1, 16'sh8000, 16'sd1, 1'b0);
    send_vertex(16'sd1, 16'sh8000, -16'sd1, 1'b0);
    send_vertex(16'sd0, 16'sd0, 16'sd32767, 1'b0);
    send_vertex(16'sd0, 16'sd16, -16'sd32767, 1'b0);
    send_vertex(-16'sd1, -16'sd1, -16'sd1, 1'b1);
    wait_idle();

    // Tiling extremes on both axes.
    set_tiling(7, 0);
    send_vertex(16'sd32767, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sh8000, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 16'sd0, 1'b0);
    send_vertex(16'sd2, -16'sd4000, 16'sd9000, 1'b1);
    wait_idle();
    set_tiling(0, 7);
    send_vertex(16'sd100, -16'sd3000, 16'sd30000, 1'b0);
    send_vertex(-16'sd100, -16'sd3000, -16'sd30000, 1'b0);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd5, 16'sd5, 16'sd32767, 1'b1);
    wait_idle();

    // Random phases, each under its own tiling. The third phase backs the
    // output up with a long hold so the block has to stall its input.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        h = 7; v = 7;
      end else if (phase == 1) begin
        h = 0; v = 0;
      end else if (phase == 2) begin
        h = 1; v = 1;
      end else begin
        h = $urandom_range(0, 7);
        v = $urandom_range(0, 7);
      end
      set_tiling(h, v);
      steady = (phase % 4 == 3);
      if (phase == 2) hold_len = LONG_HOLD;
      phase_verts = 0;
      while (phase_verts < PHASE_VERTS) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        send_strip(len);
        phase_verts += len;
      end
      wait_idle();
      steady = 1'b0;
    end

    $display("Sent %0d vertices in %0d strips under %0d tiling settings (0 to 7 on both axes).",
             verts_sent, strips_sent, settings_run);
    $display("Compared %0d result beats, with random gaps, steady stretches and one long hold.",
             beats_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/sphtex_pkg.sv
sv/spherical_texcoord_with_seam_fix.sv
verif/texcoord_checker.sv
verif/tb.sv
